>>> rtl/core/irt_pkg.sv
// Package for the interval reservation table: capacity, status codes and
// the slot word type used by the cells and the row.
// Depends on nothing.
package irt_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_BOOKED   = 2'd0;
   localparam logic [1:0] ST_CONFLICT = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_INVALID  = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [31:0] lo;
      logic [31:0] hi;
   } slot_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
   } interval_type;

endpackage

>>> rtl/core/irt_cell.sv
// One cell of the reservation row: holds one stored interval, compares it
// against the pending request and passes its word to the right on insert.
// Depends on irt_pkg.
module irt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  irt_pkg::slot_type    slot_left,
   input  irt_pkg::interval_type req,
   output irt_pkg::slot_type    slot_out,
   output logic                 hit
);
   import irt_pkg::*;

   slot_type slot_ff;
   logic     hit_ff;
   logic     hit_in;

   assign hit_in = slot_ff.valid && (slot_ff.lo < req.hi) && (slot_ff.hi > req.lo);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         if (shift_en) begin
            slot_ff <= slot_left;
         end
      end
   end

   assign slot_out = slot_ff;
   assign hit      = hit_ff;

endmodule

>>> rtl/core/irt_chain.sv
// Row of reservation cells. A booked interval enters at the first cell and
// every stored word moves one cell along; the registered hits are merged.
// Depends on irt_pkg and irt_cell.
module irt_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  irt_pkg::interval_type req,
   output logic                  conflict
);
   import irt_pkg::*;

   slot_type             link [CAPACITY+1];
   logic [CAPACITY-1:0]  hits;

   assign link[0].valid = 1'b1;
   assign link[0].lo    = req.lo;
   assign link[0].hi    = req.hi;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      irt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .slot_left (link[i]),
         .req       (req),
         .slot_out  (link[i+1]),
         .hit       (hits[i])
      );
   end

   assign conflict = |hits;

endmodule

>>> rtl/core/interval_reservation_table_core.sv
// Top level of the interval reservation table: request register, decision
// sequencer, count and response register around the cell row.
// Depends on irt_pkg and irt_chain.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall interval_start, interval_end
//   rsp      out        rsp_valid/rsp_stall booking_status, entries_used
//
// A request passes the states S_CMP and S_DEC: every cell registers its
// overlap compare in S_CMP, and the merged hit decides and inserts in S_DEC.
// The next request is accepted on the decision edge, while the last one commits.
// Reset empties the table at once through the cell valid bits.
// Under a waiting, stalled response the decision and, out of S_IDLE, req are held.
module interval_reservation_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_interval_start,
   input  logic [31:0] req_interval_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_booking_status,
   output logic [6:0]  rsp_entries_used
);
   import irt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_DEC} state_type;

   state_type    state_ff;
   interval_type req_ff;
   logic         invalid_ff;
   logic [CNT_W-1:0] count_ff;
   logic         rsp_valid_ff;
   logic [1:0]   status_ff;
   logic [6:0]   used_ff;

   logic         conflict;
   logic         can_load;
   logic         commit;
   logic         accept;
   logic         shift_en;
   logic [1:0]   status_in;
   logic [CNT_W-1:0] count_in;

   irt_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .req      (req_ff),
      .conflict (conflict)
   );

   always_comb begin
      if (invalid_ff) begin
         status_in = ST_INVALID;
      end else if (conflict) begin
         status_in = ST_CONFLICT;
      end else if (count_ff >= CNT_W'(CAPACITY)) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_BOOKED;
      end
   end

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == S_DEC) && can_load;
   assign shift_en  = commit && (status_in == ST_BOOKED);
   assign count_in  = shift_en ? count_ff + CNT_W'(1) : count_ff;
   assign req_stall = !((state_ff == S_IDLE) || commit);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            req_ff.lo  <= req_interval_start;
            req_ff.hi  <= req_interval_end;
            invalid_ff <= req_interval_end <= req_interval_start;
         end
         if (commit) begin
            status_ff    <= status_in;
            used_ff      <= 7'(count_in);
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         count_ff <= count_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               state_ff <= S_DEC;
            end
            S_DEC: begin
               if (commit) begin
                  state_ff <= accept ? S_CMP : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_booking_status = status_ff;
   assign rsp_entries_used   = used_ff;

endmodule

>>> rtl/core/irt_checker.sv
// Port-level checker for the interval reservation table, bound to the top.
// Depends on irt_pkg and interval_reservation_table_core.
module irt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_booking_status,
   input logic [6:0]  rsp_entries_used
);
   import irt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_booking_status)
                                 && $stable(rsp_entries_used))
      else $error("Stalled response word changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Request taken in the compare cycle.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response word present after reset.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_booking_status == ST_FULL) |-> rsp_entries_used == 7'(CAPACITY))
      else $error("Full status with a count below capacity.");

endmodule

bind interval_reservation_table_core irt_checker u_irt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_booking_status (rsp_booking_status),
   .rsp_entries_used   (rsp_entries_used)
);
